@@ rtl/core/esd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types of the escape sequence decoder: the queue entry that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One decoded input character: one or two result words.
    typedef struct packed {
        logic       two;      // second result follows the first
        logic [7:0] byte0;
        logic       term0;
        logic [7:0] byte1;
        logic       term1;
    } esd_entry_t;

endpackage

@@ rtl/core/esd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_front
// Accepts source characters, tracks the escape state and turns each
// character into zero, one or two result words for the queue.
// ----------------------------------------------------------------------------
module esd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          in_char,
    input  logic                queue_full,
    output logic                push,
    output esd_pkg::esd_entry_t push_entry
);
    import esd_pkg::*;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_BSLASH = 8'h5c;
    localparam logic [7:0] CHAR_N      = 8'h6e;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_E      = 8'h65;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_ESCAPE = 8'h1b;
    localparam logic [7:0] OFS_DIGIT   = 8'h30;
    localparam logic [7:0] OFS_UPPER   = 8'h37;
    localparam logic [7:0] OFS_LOWER   = 8'h57;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_DIG1,
        MODE_DIG2,
        MODE_HEX0,
        MODE_HEX1
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] partial_reg, partial_next;
    logic [7:0] first_hex_reg, first_hex_next;

    logic       accept;
    logic       idle_emit;
    logic       idle_term;
    logic [7:0] idle_byte;
    mode_t      idle_mode;
    logic       is_digit;
    logic [7:0] fold;
    esd_entry_t ent;
    logic       emit;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF);
    endfunction

    // Returns {valid, value} of an alphanumeric character.
    function automatic logic [6:0] char_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - OFS_DIGIT;
            return {1'b1, d[5:0]};
        end
        if (c >= 8'h41 && c <= 8'h5a) begin
            d = c - OFS_UPPER;
            return {1'b1, d[5:0]};
        end
        if (c >= 8'h61 && c <= 8'h7a) begin
            d = c - OFS_LOWER;
            return {1'b1, d[5:0]};
        end
        return 7'b0;
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
        logic [1:0] k;
        logic       neg;
        logic       stop;
        logic [7:0] val;
        logic [7:0] s;
        logic [6:0] cv;
        k    = 2'd0;
        neg  = 1'b0;
        stop = 1'b0;
        val  = 8'h00;
        s    = 8'h00;
        cv   = 7'b0;
        if (is_blank(a)) begin
            k = 2'd1;
            if (is_blank(b)) begin
                k = 2'd2;
            end
        end
        if (k == 2'd0 && a == CHAR_MINUS) begin
            neg = 1'b1;
            k   = 2'd1;
        end else if (k == 2'd1 && b == CHAR_MINUS) begin
            neg = 1'b1;
            k   = 2'd2;
        end
        for (int i = 0; i < 2; i++) begin
            if (!stop && k <= 2'(i)) begin
                s   = (i == 0) ? a : b;
                val = {val[3:0], 4'h0};
                cv  = char_val(s);
                if (!cv[6]) begin
                    stop = 1'b1;
                end else begin
                    val = val + {2'b00, cv[5:0]};
                end
            end
        end
        if (neg) begin
            val = 8'h00 - val;
        end
        return val;
    endfunction

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign is_digit = (in_char >= 8'h30) && (in_char <= 8'h39);
    assign fold     = {partial_reg[4:0], 3'b000} + {4'h0, in_char[3:0]};

    // Handling of a character with no escape pending.
    always_comb
    begin
        idle_emit = 1'b1;
        idle_term = 1'b0;
        idle_byte = in_char;
        idle_mode = MODE_IDLE;
        if (in_char == CHAR_NUL) begin
            idle_term = 1'b1;
        end else if (in_char == CHAR_BSLASH) begin
            idle_emit = 1'b0;
            idle_mode = MODE_ESC;
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        partial_next   = partial_reg;
        first_hex_next = first_hex_reg;
        emit           = 1'b0;
        ent            = '0;
        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_IDLE;
                emit      = 1'b1;
                ent.byte0 = in_char;
                if (in_char == CHAR_NUL) begin
                    ent.term0      = 1'b1;
                    partial_next   = 8'h00;
                    first_hex_next = 8'h00;
                end else if (in_char == CHAR_N) begin
                    ent.byte0 = CHAR_LF;
                end else if (in_char == CHAR_R) begin
                    ent.byte0 = CHAR_CR;
                end else if (in_char == CHAR_T) begin
                    ent.byte0 = CHAR_TAB;
                end else if (in_char == CHAR_E) begin
                    ent.byte0 = CHAR_ESCAPE;
                end else if (in_char == CHAR_X) begin
                    emit      = 1'b0;
                    mode_next = MODE_HEX0;
                end else if (is_digit) begin
                    emit         = 1'b0;
                    partial_next = {4'h0, in_char[3:0]};
                    mode_next    = MODE_DIG1;
                end
            end
            MODE_DIG1, MODE_DIG2:
            begin
                emit = 1'b1;
                if (is_digit && mode_reg == MODE_DIG1) begin
                    emit         = 1'b0;
                    partial_next = fold;
                    mode_next    = MODE_DIG2;
                end else if (is_digit) begin
                    ent.byte0    = fold;
                    partial_next = 8'h00;
                    mode_next    = MODE_IDLE;
                end else begin
                    // The digit run ends early: its value goes out first, then
                    // the character is handled as if no escape were pending.
                    ent.byte0    = partial_reg;
                    ent.two      = idle_emit;
                    ent.byte1    = idle_byte;
                    ent.term1    = idle_term;
                    partial_next = 8'h00;
                    mode_next    = idle_mode;
                    if (idle_term) begin
                        first_hex_next = 8'h00;
                    end
                end
            end
            MODE_HEX0:
            begin
                if (in_char == CHAR_NUL) begin
                    emit           = 1'b1;
                    ent.term0      = 1'b1;
                    mode_next      = MODE_IDLE;
                    partial_next   = 8'h00;
                    first_hex_next = 8'h00;
                end else begin
                    first_hex_next = in_char;
                    mode_next      = MODE_HEX1;
                end
            end
            MODE_HEX1:
            begin
                emit           = 1'b1;
                mode_next      = MODE_IDLE;
                first_hex_next = 8'h00;
                if (in_char == CHAR_NUL) begin
                    ent.term0    = 1'b1;
                    partial_next = 8'h00;
                end else begin
                    ent.byte0 = hex_pair(first_hex_reg, in_char);
                end
            end
            default:
            begin
                emit      = idle_emit;
                ent.byte0 = idle_byte;
                ent.term0 = idle_term;
                mode_next = idle_mode;
                if (idle_term) begin
                    partial_next   = 8'h00;
                    first_hex_next = 8'h00;
                end
            end
        endcase
    end

    assign push       = accept && emit;
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_IDLE;
            partial_reg   <= 8'h00;
            first_hex_reg <= 8'h00;
        end else if (accept) begin
            mode_reg      <= mode_next;
            partial_reg   <= partial_next;
            first_hex_reg <= first_hex_next;
        end
    end

endmodule

@@ rtl/core/esd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_queue
// Short first-in first-out queue of decoded entries between the front end
// and the back end.
// ----------------------------------------------------------------------------
module esd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  esd_pkg::esd_entry_t push_entry,
    input  logic                pop,
    output esd_pkg::esd_entry_t head,
    output logic                empty,
    output logic                full
);
    import esd_pkg::*;

    esd_entry_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/esd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_back
// Takes entries from the queue and presents their result words one at a
// time in the output register.
// ----------------------------------------------------------------------------
module esd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  esd_pkg::esd_entry_t head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                is_terminator,
    output logic                last_of_run
);
    import esd_pkg::*;

    logic       valid_reg;
    logic       second_reg;
    logic [7:0] byte_reg;
    logic       term_reg;
    logic       last_reg;
    logic       load;
    logic       first_of_two;

    assign load         = !empty && (!valid_reg || !out_stall);
    // The first word of a two-word entry leaves the entry in the queue.
    assign first_of_two = head.two && !second_reg;
    assign pop          = load && !first_of_two;

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign is_terminator = term_reg;
    assign last_of_run   = last_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            if (first_of_two) begin
                byte_reg <= head.byte0;
                term_reg <= head.term0;
                last_reg <= 1'b0;
            end else begin
                byte_reg <= head.two ? head.byte1 : head.byte0;
                term_reg <= head.two ? head.term1 : head.term0;
                last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg  <= 1'b1;
                second_reg <= first_of_two;
            end else if (!out_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/escape_sequence_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Decodes C-style escape sequences in a character stream, one character at a
// time, and emits the decoded bytes and an end-of-string terminator.
// ----------------------------------------------------------------------------
// A character is taken in every cycle that in_valid is high and in_stall
// is low. Each character yields zero, one or two result words. The
// decoder writes a character's words into the queue at the edge that
// accepts it, and the output register then loads the first of them from
// the queue once it is free. Characters that give one word or none run
// at one per cycle while out_stall is low. A character that gives two
// words (a digit escape cut short by another character) occupies the
// single output register once for each word. The two-entry queue between
// decoder and output then fills, and in_stall follows the full flag
// without looking at a read in the same cycle, so the input stalls unless
// a character that gives no word follows first.
// ----------------------------------------------------------------------------
module escape_sequence_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_terminator,
    output logic       last_of_run
);
    import esd_pkg::*;

    logic       push;
    esd_entry_t push_entry;
    logic       pop;
    esd_entry_t head;
    logic       empty;
    logic       full;

    esd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    esd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    esd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape sequence decoder. Directed strings
// cover plain bytes, each escape kind and escapes cut by end of string.
// Random strings built mostly from well-formed escapes follow. A built-in
// decoder predicts every result word, and the output is checked word by
// word under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

    import esd_pkg::*;

    localparam int RANDOM_CHARS = 1900;
    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 9;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_START,
        ESC_DIG1,
        ESC_DIG2,
        ESC_HEX0,
        ESC_HEX1
    } esc_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic       term;
        logic       tail;
    } decoded_word_t;

    class decode_scoreboard;
        decoded_word_t expected_words[$];
        decoded_word_t step_words[$];
        esc_mode_t     mode = ESC_IDLE;
        logic [7:0]    folded = 8'd0;
        logic [7:0]    hex_first = 8'd0;
        int            errors = 0;
        int            words_checked = 0;
        int            terminators = 0;
        int            chars_taken = 0;

        function automatic bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function automatic bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF;
        endfunction

        // Digits count 0..9, letters of either case 10..35, anything else -1.
        function automatic int alnum_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c) - 48;
            if (c >= "A" && c <= "Z")
                return int'(c) - 55;
            if (c >= "a" && c <= "z")
                return int'(c) - 87;
            return -1;
        endfunction

        function automatic logic [7:0] hex_value(logic [7:0] a, logic [7:0] b);
            logic [7:0] pair [2];
            int         k;
            int         v;
            bit         neg;
            bit         stop;
            logic [7:0] acc;
            pair[0] = a;
            pair[1] = b;
            k = 0;
            neg = 1'b0;
            stop = 1'b0;
            acc = 8'd0;
            while (k < 2 && is_blank(pair[k]))
                k++;
            if (k < 2 && pair[k] == CH_MINUS)
            begin
                neg = 1'b1;
                k++;
            end
            // The shift happens even for the character that stops the pair.
            while (k < 2 && !stop)
            begin
                acc = acc * 8'd16;
                v = alnum_value(pair[k]);
                if (v < 0)
                    stop = 1'b1;
                else
                begin
                    acc = acc + v[7:0];
                    k++;
                end
            end
            if (neg)
                acc = 8'd0 - acc;
            return acc;
        endfunction

        function void add_word(logic [7:0] v, logic t);
            decoded_word_t w;
            w.value = v;
            w.term = t;
            w.tail = 1'b0;
            step_words.push_back(w);
        endfunction

        function void clear_state();
            mode = ESC_IDLE;
            folded = 8'd0;
            hex_first = 8'd0;
        endfunction

        function void plain_char(logic [7:0] c);
            if (c == CH_NUL)
            begin
                add_word(CH_NUL, 1'b1);
                clear_state();
            end
            else if (c == CH_BSLASH)
                mode = ESC_START;
            else
                add_word(c, 1'b0);
        endfunction

        function void take_char(logic [7:0] c);
            step_words.delete();
            chars_taken++;
            case (mode)
                ESC_START:
                begin
                    mode = ESC_IDLE;
                    if (c == CH_NUL)
                    begin
                        add_word(CH_NUL, 1'b1);
                        clear_state();
                    end
                    else if (c == CH_N)
                        add_word(CH_LF, 1'b0);
                    else if (c == CH_R)
                        add_word(CH_CR, 1'b0);
                    else if (c == CH_T)
                        add_word(CH_TAB, 1'b0);
                    else if (c == CH_E)
                        add_word(CH_ESC, 1'b0);
                    else if (c == CH_X)
                        mode = ESC_HEX0;
                    else if (is_digit(c))
                    begin
                        folded = c - CH_ZERO;
                        mode = ESC_DIG1;
                    end
                    else
                        add_word(c, 1'b0);
                end
                ESC_DIG1, ESC_DIG2:
                begin
                    if (is_digit(c) && mode == ESC_DIG1)
                    begin
                        folded = folded * 8'd8 + (c - CH_ZERO);
                        mode = ESC_DIG2;
                    end
                    else if (is_digit(c))
                    begin
                        add_word(folded * 8'd8 + (c - CH_ZERO), 1'b0);
                        mode = ESC_IDLE;
                        folded = 8'd0;
                    end
                    else
                    begin
                        // A short digit run is flushed before the new character.
                        add_word(folded, 1'b0);
                        mode = ESC_IDLE;
                        folded = 8'd0;
                        plain_char(c);
                    end
                end
                ESC_HEX0:
                begin
                    if (c == CH_NUL)
                    begin
                        add_word(CH_NUL, 1'b1);
                        clear_state();
                    end
                    else
                    begin
                        hex_first = c;
                        mode = ESC_HEX1;
                    end
                end
                ESC_HEX1:
                begin
                    if (c == CH_NUL)
                    begin
                        add_word(CH_NUL, 1'b1);
                        clear_state();
                    end
                    else
                    begin
                        add_word(hex_value(hex_first, c), 1'b0);
                        mode = ESC_IDLE;
                        hex_first = 8'd0;
                    end
                end
                default:
                begin
                    mode = ESC_IDLE;
                    plain_char(c);
                end
            endcase
            if (step_words.size() > 0)
                step_words[step_words.size() - 1].tail = 1'b1;
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        endfunction

        function void check_word(logic [7:0] v, logic t, logic l);
            decoded_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_byte 0x%02h is_terminator %0d last_of_run %0d",
                       v, t, l);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            words_checked++;
            if (w.term)
                terminators++;
            if (v !== w.value)
            begin
                $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", w.value, v);
                errors++;
            end
            if (t !== w.term)
            begin
                $error("is_terminator mismatch: expected %0d, actual %0d", w.term, t);
                errors++;
            end
            if (l !== w.tail)
            begin
                $error("last_of_run mismatch: expected %0d, actual %0d", w.tail, l);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_char = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       is_terminator;
    logic       last_of_run;

    decode_scoreboard board = new();
    int  stuck_cycles = 0;
    int  chars_sent = 0;
    bit  calm = 1'b0;

    logic [7:0] opening_chars [$] = '{
        8'hff, 8'h01, "$",
        CH_BSLASH, CH_N, CH_BSLASH, CH_E,
        CH_BSLASH, "3", "7", "7",
        CH_BSLASH, "1", "Z",
        CH_BSLASH, "9", "8", CH_BSLASH, CH_X, CH_MINUS, "1",
        CH_BSLASH, CH_X, CH_SPACE, "F",
        CH_BSLASH, CH_NUL,
        CH_BSLASH, "5", CH_NUL,
        CH_BSLASH, CH_X, "A", CH_NUL,
        CH_NUL
    };

    escape_sequence_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_char       (in_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_char(in_char);
            if (out_valid && !out_stall)
                board.check_word(out_byte, is_terminator, last_of_run);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("Watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_char(input logic [7:0] c);
        bit took;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_char <= c;
        // in_stall is settled by the falling edge and holds until the next rise.
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        chars_sent++;
    endtask

    function automatic logic [7:0] pick_hex_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 45)
            return "a" + 8'($urandom_range(0, 5));
        if (r < 55)
            return "A" + 8'($urandom_range(0, 25));
        if (r < 65)
            return "a" + 8'($urandom_range(0, 25));
        if (r < 75)
        begin
            case ($urandom_range(0, 2))
                0: return CH_SPACE;
                1: return CH_TAB;
                default: return CH_LF;
            endcase
        end
        if (r < 85)
            return CH_MINUS;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_random_piece();
        int r;
        int ndig;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_char(8'($urandom_range(1, 255)));
        else if (r < 40)
        begin
            send_char(CH_BSLASH);
            case ($urandom_range(0, 3))
                0: send_char(CH_N);
                1: send_char(CH_R);
                2: send_char(CH_T);
                default: send_char(CH_E);
            endcase
        end
        else if (r < 58)
        begin
            // One or two digits leave the run open for whatever comes next.
            send_char(CH_BSLASH);
            ndig = $urandom_range(1, 3);
            repeat (ndig)
                send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (r < 75)
        begin
            send_char(CH_BSLASH);
            send_char(CH_X);
            send_char(pick_hex_char());
            send_char(pick_hex_char());
        end
        else if (r < 82)
        begin
            send_char(CH_BSLASH);
            send_char(8'($urandom_range(1, 255)));
        end
        else if (r < 90)
            send_char(CH_NUL);
        else if (r < 95)
        begin
            send_char(CH_BSLASH);
            case ($urandom_range(0, 2))
                0: ;
                1: send_char(CH_X);
                default:
                begin
                    send_char(CH_X);
                    send_char(pick_hex_char());
                end
            endcase
            send_char(CH_NUL);
        end
        else
            send_char(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int random_start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_chars[i])
            send_char(opening_chars[i]);

        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS)
        begin
            calm = (chars_sent - random_start > 700) && (chars_sent - random_start < 1100);
            send_random_piece();
        end
        calm = 1'b0;
        send_char(CH_NUL);
        in_valid <= 1'b0;

        while (board.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d characters into %0d checked words, %0d of them terminators.",
                 board.chars_taken, board.words_checked, board.terminators);
        $display("Covered plain bytes, named, digit and hex escapes, and escapes cut by end.");
        if (board.errors == 0 && board.expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/esd_pkg.sv
rtl/core/esd_front.sv
rtl/core/esd_queue.sv
rtl/core/esd_back.sv
rtl/core/escape_sequence_decoder.sv
test/tb.sv
